[rtl/sjgl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjgl_pkg
// Shared constants, types and helpers for the Shift-JIS glyph locator.
// ----------------------------------------------------------------------------
package sjgl_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int DIST_W     = 21;
    localparam int SIZE_W     = 9;
    localparam int PROD_W     = DIST_W + SIZE_W;

    // register indexes
    localparam logic [2:0] REG_FULL_W   = 3'd0;
    localparam logic [2:0] REG_FULL_H   = 3'd1;
    localparam logic [2:0] REG_HALF_W   = 3'd2;
    localparam logic [2:0] REG_HALF_H   = 3'd3;
    localparam logic [2:0] REG_BLK_CNT  = 3'd4;
    localparam logic [2:0] REG_SCREEN_W = 3'd5;
    localparam logic [2:0] REG_SCREEN_H = 3'd6;

    localparam logic [23:0] OFS_MAX       = 24'hffffff;
    localparam logic [7:0]  HALF_HDR_SIZE = 8'd17;
    localparam logic [7:0]  FULL_HDR_SIZE = 8'd18;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] idx;
        logic [15:0]       blk_first;
        logic [15:0]       blk_last;
    } t_tbl_wr;

    typedef struct packed {
        logic               start;
        logic [15:0]        code;
        logic [COUNT_W-1:0] count;
    } t_walk_req;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [DIST_W-1:0] rank;
    } t_walk_rsp;

    function automatic logic is_lead(input logic [7:0] b);
        return b inside {[8'h81:8'h9f], [8'he0:8'hfc]};
    endfunction

    // bytes per glyph: ceil(w / 8) * h
    function automatic logic [SIZE_W-1:0] glyph_size(input logic [5:0] w,
                                                     input logic [5:0] h);
        logic [6:0] s;
        s = {1'b0, w} + 7'd7;
        return {5'b0, s[6:3]} * {3'b0, h};
    endfunction

endpackage

[rtl/sjgl_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjgl_table
// Code-block table memory and the walk that counts codes ahead of a match.
// ----------------------------------------------------------------------------
module sjgl_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sjgl_pkg::t_tbl_wr  i_wr,
    input  sjgl_pkg::t_walk_req i_req,
    output sjgl_pkg::t_walk_rsp o_rsp
);

    logic [31:0] r_mem [sjgl_pkg::MAX_BLOCKS];
    logic [31:0] r_rd;

    logic                         r_active;
    logic                         r_vld;
    logic [sjgl_pkg::COUNT_W-1:0] r_addr;
    logic [sjgl_pkg::COUNT_W-1:0] r_count;
    logic [15:0]                  r_code;
    logic [sjgl_pkg::DIST_W-1:0]  r_before;

    logic        issue;
    logic [15:0] s_first;
    logic [15:0] s_last;
    logic        ordered;
    logic        hit;
    logic        miss_end;

    assign issue    = r_active && (r_addr < r_count);
    assign s_first  = r_rd[15:0];
    assign s_last   = r_rd[31:16];
    assign ordered  = s_last >= s_first;
    assign hit      = ordered && (r_code >= s_first) && (r_code <= s_last);
    assign miss_end = !r_vld && (r_addr == r_count);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= {i_wr.blk_last, i_wr.blk_first};
        end
        if (issue) begin
            r_rd <= r_mem[r_addr[sjgl_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_vld    <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_vld <= issue;
            if (i_req.start) begin
                r_active <= 1'b1;
                r_addr   <= '0;
            end else begin
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_active && ((r_vld && hit) || miss_end)) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_code   <= i_req.code;
            r_count  <= i_req.count;
            r_before <= '0;
        end else if (r_active && r_vld && ordered && !hit) begin
            r_before <= r_before + {5'b0, s_last - s_first} + 1'b1;
        end
    end

    assign o_rsp.done  = r_active && ((r_vld && hit) || miss_end);
    assign o_rsp.found = r_vld && hit;
    assign o_rsp.rank  = r_before + {5'b0, r_code - s_first};

endmodule

[rtl/sjis_glyph_locator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjis_glyph_locator
// Resolves Shift-JIS text to glyph offsets and places glyphs with a cursor.
// ----------------------------------------------------------------------------
// channel   dir  transaction
// s_axis    in   tuser[0]=action, tdata = block entry fields / text byte
// m_axis    out  tuser[0]=is_full_width, tdata = code, found, offset, x, y, w, h
// cfg       in   one register write per cycle with i_cfg_we
//
// Table loads and lead bytes are handled in S_IDLE. Half-width characters
// pass through S_HMUL (multiply) and S_FIN (place). Full-width characters
// walk the table (block_count capped at 16, a hit ends the walk early), one
// memory read per entry pipelined against the compare, then multiply, place.
// A finished result waits in the output register; the next item is taken
// meanwhile, and only a second result stalls on m_axis tready.
// Synchronous active-low reset; the table memory is not cleared.
// ----------------------------------------------------------------------------
module sjis_glyph_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] block_index, [19:4] block_start, [35:20] block_end,
    // [43:36] text_byte, [47:44] zero
    input  logic [47:0] i_s_axis_tdata,
    // [0] action
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] glyph_code, [16] glyph_found, [40:17] glyph_offset,
    // [50:41] glyph_x, [60:51] glyph_y, [66:61] glyph_width,
    // [72:67] glyph_height, [79:73] zero
    output logic [79:0] o_m_axis_tdata,
    // [0] is_full_width
    output logic [0:0]  o_m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [10:0] i_cfg_wdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_HMUL = 3'd2;
    localparam logic [2:0] S_FMUL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]  r_state;

    logic [5:0]  r_full_w, r_full_h, r_half_w, r_half_h;
    logic [4:0]  r_blk_cnt;
    logic [10:0] r_screen_w, r_screen_h;
    logic [sjgl_pkg::SIZE_W-1:0] r_full_size, r_half_size;

    logic        r_lead_pending;
    logic [7:0]  r_lead_byte;
    logic [9:0]  r_cur_x, r_cur_y;

    logic [15:0] r_code;
    logic        r_full;
    logic        r_found;
    logic [sjgl_pkg::DIST_W-1:0] r_dist;
    logic [sjgl_pkg::PROD_W-1:0] r_prod;

    logic        r_out_valid;
    logic [79:0] r_out_data;
    logic        r_out_full;

    logic        accept;
    logic        act_text;
    logic [7:0]  in_byte;
    logic [sjgl_pkg::COUNT_W-1:0] blk_n;

    sjgl_pkg::t_tbl_wr   tbl_wr;
    sjgl_pkg::t_walk_req walk_req;
    sjgl_pkg::t_walk_rsp walk_rsp;

    logic [5:0]  cw, ch;
    logic [10:0] x_end;
    logic        wrap;
    logic [9:0]  y_step;
    logic [10:0] y_end;
    logic [9:0]  out_x, out_y;
    logic [30:0] full_ofs;
    logic [23:0] ofs;
    logic        emit;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign act_text = i_s_axis_tuser[0];
    assign in_byte  = i_s_axis_tdata[43:36];
    assign blk_n    = (r_blk_cnt > 5'(sjgl_pkg::MAX_BLOCKS))
                    ? sjgl_pkg::COUNT_W'(sjgl_pkg::MAX_BLOCKS)
                    : sjgl_pkg::COUNT_W'(r_blk_cnt);

    assign o_s_axis_tready = (r_state == S_IDLE);

    assign tbl_wr.en        = accept && !act_text;
    assign tbl_wr.idx       = i_s_axis_tdata[3:0];
    assign tbl_wr.blk_first = i_s_axis_tdata[19:4];
    assign tbl_wr.blk_last  = i_s_axis_tdata[35:20];

    assign walk_req.start = accept && act_text && r_lead_pending;
    assign walk_req.code  = {r_lead_byte, in_byte};
    assign walk_req.count = blk_n;

    sjgl_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tbl_wr),
        .i_req   (walk_req),
        .o_rsp   (walk_rsp)
    );

    // placement and offset
    always_comb begin
        cw     = r_full ? r_full_w : r_half_w;
        ch     = r_full ? r_full_h : r_half_h;
        x_end  = {1'b0, r_cur_x} + {5'b0, cw};
        wrap   = x_end >= r_screen_w;
        y_step = r_cur_y + {4'b0, ch};
        y_end  = {1'b0, y_step} + {5'b0, ch};
        out_x  = wrap ? 10'd0 : r_cur_x;
        out_y  = wrap ? ((y_end >= r_screen_h) ? 10'd0 : y_step) : r_cur_y;
        full_ofs = {1'b0, r_prod} + {23'b0, sjgl_pkg::FULL_HDR_SIZE}
                 + {24'b0, blk_n, 2'b0};
        if (!r_full) begin
            ofs = r_prod[23:0] + {16'b0, sjgl_pkg::HALF_HDR_SIZE};
        end else if (!r_found) begin
            ofs = '0;
        end else if (|full_ofs[30:24]) begin
            ofs = sjgl_pkg::OFS_MAX;
        end else begin
            ofs = full_ofs[23:0];
        end
        emit = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_w   <= 6'd16;
            r_full_h   <= 6'd16;
            r_half_w   <= 6'd8;
            r_half_h   <= 6'd16;
            r_blk_cnt  <= 5'd0;
            r_screen_w <= 11'd256;
            r_screen_h <= 11'd224;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sjgl_pkg::REG_FULL_W:   r_full_w   <= i_cfg_wdata[5:0];
                sjgl_pkg::REG_FULL_H:   r_full_h   <= i_cfg_wdata[5:0];
                sjgl_pkg::REG_HALF_W:   r_half_w   <= i_cfg_wdata[5:0];
                sjgl_pkg::REG_HALF_H:   r_half_h   <= i_cfg_wdata[5:0];
                sjgl_pkg::REG_BLK_CNT:  r_blk_cnt  <= i_cfg_wdata[4:0];
                sjgl_pkg::REG_SCREEN_W: r_screen_w <= i_cfg_wdata;
                sjgl_pkg::REG_SCREEN_H: r_screen_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_full_size <= sjgl_pkg::glyph_size(r_full_w, r_full_h);
        r_half_size <= sjgl_pkg::glyph_size(r_half_w, r_half_h);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_lead_pending <= 1'b0;
            r_lead_byte    <= 8'd0;
            r_cur_x        <= 10'd0;
            r_cur_y        <= 10'd0;
            r_out_valid    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && act_text) begin
                        if (r_lead_pending) begin
                            r_lead_pending <= 1'b0;
                            r_state        <= S_WALK;
                        end else if (sjgl_pkg::is_lead(in_byte)) begin
                            r_lead_pending <= 1'b1;
                            r_lead_byte    <= in_byte;
                        end else begin
                            r_state <= S_HMUL;
                        end
                    end
                end
                S_WALK: begin
                    if (walk_rsp.done) begin
                        r_state <= S_FMUL;
                    end
                end
                S_HMUL:  r_state <= S_FIN;
                S_FMUL:  r_state <= S_FIN;
                S_FIN: begin
                    if (emit) begin
                        r_cur_x <= out_x + {4'b0, cw};
                        r_cur_y <= out_y;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept && act_text) begin
            r_code <= r_lead_pending ? {r_lead_byte, in_byte} : {8'd0, in_byte};
            r_full <= r_lead_pending;
        end
        if (r_state == S_WALK && walk_rsp.done) begin
            r_found <= walk_rsp.found;
            r_dist  <= walk_rsp.rank;
        end
        if (r_state == S_HMUL) begin
            r_found <= 1'b1;
            r_prod  <= {13'b0, {9'b0, r_code[7:0]} * {8'b0, r_half_size}};
        end
        if (r_state == S_FMUL) begin
            r_prod <= {9'b0, r_dist} * {21'b0, r_full_size};
        end
        if (emit) begin
            r_out_data <= {7'b0, ch, cw, out_y, out_x, ofs, r_found, r_code};
            r_out_full <= r_full;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_full;

endmodule
